/* rtl/core/cksd_pkg.sv */
// Shared types, codes and constants of the calculator key scanner and display.
package cksd_pkg;

    // Default display size; the top level takes it as a parameter.
    localparam int DISPLAY_DIGITS_DEF = 8;

    // Key lines 0 to SCAN_LINES-1 are scanned; LINE_IDLE marks a stopped scan.
    localparam int          SCAN_LINES = 9;
    localparam logic [3:0]  LINE_LAST  = 4'd8;
    localparam logic [3:0]  LINE_IDLE  = 4'd9;

    localparam logic [7:0]  READ_NONE  = 8'hFF;
    localparam logic [7:0]  START_ACK  = 8'd1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_PULSE = 2'd1,
        OP_READ  = 2'd2,
        OP_SENSE = 2'd3
    } op_t;

    // Key codes: 0 to 9 are digits, the rest are named below.
    typedef logic [4:0] key_t;
    localparam key_t KEY_CLEAR = 5'd16;
    localparam key_t KEY_POINT = 5'd17;
    localparam key_t KEY_NONE  = 5'd18;
    localparam key_t KEY_DIGIT_MAX = 5'd9;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] pulse_status;
        logic [7:0] digit_index;
        logic       sense_select;
        logic       key_pressed;
    } req_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [3:0] line_now;
        logic [3:0] digit_count;
        logic       point_valid;
        logic [3:0] point_position;
    } rsp_t;

    // Control from the scan sequencer to the digit entry logic.
    typedef struct packed {
        logic apply;
        key_t key_a;
        key_t key_b;
    } entry_ctl_t;

    // Status from the digit entry logic: display state after the step and read data.
    typedef struct packed {
        logic [3:0] digit_count;
        logic       point_valid;
        logic [3:0] point_position;
        logic [7:0] rd_value;
    } entry_stat_t;

    // Key found in the function column of a given line.
    function automatic key_t function_key(logic [3:0] line);
        key_t key;
        begin
            unique case (line)
                4'd0:      key = KEY_CLEAR;
                4'd7:      key = KEY_POINT;
                LINE_LAST: key = 5'd0;
                default:   key = KEY_NONE;
            endcase
            return key;
        end
    endfunction

endpackage

/* rtl/core/cksd_if.sv */
// Request and response channel interfaces of the calculator key scanner.
interface cksd_req_if;
    logic               valid;
    logic               ready;
    cksd_pkg::req_t     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cksd_rsp_if;
    logic               valid;
    logic               ready;
    cksd_pkg::rsp_t     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/cksd_entry.sv */
// Digit store and key entry logic: applies up to two keys per step and serves digit reads.
module cksd_entry #(
    parameter int DISPLAY_DIGITS = cksd_pkg::DISPLAY_DIGITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cksd_pkg::entry_ctl_t    ctl,
    input  logic [7:0]              rd_index,
    output cksd_pkg::entry_stat_t   stat
);

    localparam int LEN_W = $clog2(DISPLAY_DIGITS + 1);
    localparam int IDX_W = (DISPLAY_DIGITS > 1) ? $clog2(DISPLAY_DIGITS) : 1;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             pflag;
        logic [3:0]       pat;
        logic             zero0;
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [3:0]       data;
    } step_t;

    logic [LEN_W-1:0] len_reg;
    logic             pflag_reg;
    logic [3:0]       pat_reg;
    logic [3:0]       store_reg  [DISPLAY_DIGITS];
    logic [3:0]       store_next [DISPLAY_DIGITS];

    step_t s0;
    step_t s1;
    step_t s2;

    // One key press applied to the display state.
    function automatic step_t press(step_t s, cksd_pkg::key_t key);
        step_t r;
        begin
            r      = s;
            r.we   = 1'b0;
            r.addr = '0;
            r.data = '0;
            if (key == cksd_pkg::KEY_CLEAR)
            begin
                r.len   = LEN_W'(1);
                r.pflag = 1'b0;
                r.pat   = 4'd0;
                r.zero0 = 1'b1;
                r.we    = 1'b1;
            end
            else if (key == cksd_pkg::KEY_POINT)
            begin
                if (!s.pflag)
                begin
                    r.pflag = 1'b1;
                    r.pat   = 4'(s.len);
                end
            end
            else if (key <= cksd_pkg::KEY_DIGIT_MAX)
            begin
                if (s.len == LEN_W'(1) && s.zero0 && !s.pflag)
                begin
                    // A lone zero is replaced by the new digit.
                    r.we    = 1'b1;
                    r.data  = key[3:0];
                    r.zero0 = (key[3:0] == 4'd0);
                end
                else if (s.len < LEN_W'(DISPLAY_DIGITS))
                begin
                    r.we   = 1'b1;
                    r.addr = s.len[IDX_W-1:0];
                    r.data = key[3:0];
                    r.len  = s.len + LEN_W'(1);
                end
            end
            return r;
        end
    endfunction

    always_comb
    begin
        s0       = '0;
        s0.len   = len_reg;
        s0.pflag = pflag_reg;
        s0.pat   = pat_reg;
        s0.zero0 = (store_reg[0] == 4'd0);
        s1       = press(s0, ctl.key_a);
        s2       = press(s1, ctl.key_b);
    end

    // The function column key is applied after the digit column key, so its write wins.
    always_comb
    begin
        for (int i = 0; i < DISPLAY_DIGITS; i++)
        begin
            store_next[i] = store_reg[i];
            if (ctl.apply && s2.we && s2.addr == IDX_W'(i))
            begin
                store_next[i] = s2.data;
            end
            else if (ctl.apply && s1.we && s1.addr == IDX_W'(i))
            begin
                store_next[i] = s1.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_W'(1);
            pflag_reg <= 1'b0;
            pat_reg   <= 4'd0;
            for (int i = 0; i < DISPLAY_DIGITS; i++)
            begin
                store_reg[i] <= 4'd0;
            end
        end
        else
        begin
            if (ctl.apply)
            begin
                len_reg   <= s2.len;
                pflag_reg <= s2.pflag;
                pat_reg   <= s2.pat;
            end
            for (int i = 0; i < DISPLAY_DIGITS; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    always_comb
    begin
        stat.digit_count    = ctl.apply ? 4'(s2.len) : 4'(len_reg);
        stat.point_valid    = ctl.apply ? s2.pflag : pflag_reg;
        stat.point_position = 4'd0;
        if (stat.point_valid)
        begin
            stat.point_position = ctl.apply ? s2.pat : pat_reg;
        end
        if ({1'b0, rd_index} >= 9'(len_reg))
        begin
            stat.rd_value = cksd_pkg::READ_NONE;
        end
        else
        begin
            stat.rd_value = {4'd0, store_reg[rd_index[IDX_W-1:0]]};
        end
    end

endmodule

/* rtl/core/calculator_key_scan_display_unit.sv */
// Top level of the calculator key-line scanner and digit-entry display.
//
// The unit takes one request per clock cycle on req while rsp is not stalled
// and answers each with one response on rsp, in order. A request is registered
// in the request register on acceptance and worked on once it advances, when
// the scan line, the digit store and the point state are updated and the
// response is loaded into the output register, from which it is offered on
// rsp. The sustained rate is one request per cycle while rsp is not stalled;
// it is set by the single pass through the key entry logic, which applies up
// to two keys (the digit column key first, then the function column key)
// between the request register and the response register. A stall on rsp
// holds the output register and, once the request register is also full,
// drops req.ready in the same cycle. A start scan request sets the key line
// to 0 and answers 1; a scan pulse injects the keys its status bits select,
// advances the line and answers 0, and a pulse while the scan is idle
// changes nothing; a read returns a stored digit or 255 past the display
// length; a sense check returns key_pressed while a scan is running and 0
// while idle. Every response also carries the key line, the digit count and
// the point state as they stand after the request.
module calculator_key_scan_display_unit #(
    parameter int DISPLAY_DIGITS = cksd_pkg::DISPLAY_DIGITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    cksd_req_if.sink        req,
    cksd_rsp_if.source      rsp
);

    // Request register in front of the entry logic.
    logic                   s1_valid_reg;
    cksd_pkg::req_t         s1_req_reg;
    logic                   advance;

    // Scan line state; holds 0 to 8 while scanning, LINE_IDLE otherwise.
    logic [3:0]             line_reg;
    logic [3:0]             line_next;
    logic                   active;

    // Response register.
    logic                   rsp_valid_reg;
    cksd_pkg::rsp_t         rsp_reg;
    cksd_pkg::rsp_t         rsp_next;

    cksd_pkg::entry_ctl_t   entry_ctl;
    cksd_pkg::entry_stat_t  entry_stat;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign active    = (line_reg < 4'(cksd_pkg::SCAN_LINES));

    // Keys of the current line; only a pulse on a running scan injects them.
    always_comb
    begin
        entry_ctl.apply = advance && (s1_req_reg.opcode == cksd_pkg::OP_PULSE) && active;
        entry_ctl.key_a = s1_req_reg.pulse_status[0] ? (cksd_pkg::key_t'(line_reg) + 5'd1)
                                                     : cksd_pkg::KEY_NONE;
        entry_ctl.key_b = s1_req_reg.pulse_status[1] ? cksd_pkg::function_key(line_reg)
                                                     : cksd_pkg::KEY_NONE;
    end

    cksd_entry #(
        .DISPLAY_DIGITS (DISPLAY_DIGITS)
    ) u_entry (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (entry_ctl),
        .rd_index (s1_req_reg.digit_index),
        .stat     (entry_stat)
    );

    always_comb
    begin
        line_next           = line_reg;
        rsp_next.read_value = 8'd0;
        unique case (s1_req_reg.opcode)
            cksd_pkg::OP_START:
            begin
                line_next           = 4'd0;
                rsp_next.read_value = cksd_pkg::START_ACK;
            end
            cksd_pkg::OP_PULSE:
            begin
                if (active)
                begin
                    line_next = (line_reg == cksd_pkg::LINE_LAST) ? cksd_pkg::LINE_IDLE
                                                                  : line_reg + 4'd1;
                end
            end
            cksd_pkg::OP_READ:
            begin
                rsp_next.read_value = entry_stat.rd_value;
            end
            cksd_pkg::OP_SENSE:
            begin
                // Either column answers with the held state of the tested key.
                rsp_next.read_value = {7'd0, active && s1_req_reg.key_pressed};
            end
            default:
            begin
                line_next = line_reg;
            end
        endcase
        rsp_next.line_now       = line_next;
        rsp_next.digit_count    = entry_stat.digit_count;
        rsp_next.point_valid    = entry_stat.point_valid;
        rsp_next.point_position = entry_stat.point_position;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            line_reg      <= cksd_pkg::LINE_IDLE;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                line_reg      <= line_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_req_reg <= req.data;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

endmodule

/* rtl/core/cksd_checker.sv */
// Port-level checks of the calculator key scanner, bound to its top level.
module cksd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input cksd_pkg::rsp_t   rsp_data
);

    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response withdrawn while stalled");

    // A response only appears when a request was taken before it.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without a matching request");

    // The key line never leaves the scan range or the idle mark.
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.line_now <= cksd_pkg::LINE_IDLE)
        else $error("key line out of range");

    // Without a point the point position reads as zero.
    a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.point_valid |-> rsp_data.point_position == 4'd0)
        else $error("point position set without a point");

endmodule

bind calculator_key_scan_display_unit cksd_checker u_cksd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
